[sv/aug_pkg.sv]
// Package for the atomic update hazard gate: request and result payload types
// and the stall status codes. No dependencies.
package aug_pkg;

    localparam int unsigned IO_ID_W = 32;

    localparam logic [1:0] ST_ACCEPT     = 2'd0;
    localparam logic [1:0] ST_STALL_FIRST = 2'd1;
    localparam logic [1:0] ST_STALL_CONT  = 2'd2;

    typedef struct packed {
        logic               request_valid;
        logic [IO_ID_W-1:0] request_vertex;
        logic [IO_ID_W-1:0] request_edge;
        logic               downstream_can_accept;
        logic               op_complete;
    } t_req;

    typedef struct packed {
        logic               issue_valid;
        logic [IO_ID_W-1:0] issue_vertex;
        logic [IO_ID_W-1:0] issue_edge;
        logic [1:0]         stall_status;
    } t_res;

endpackage

[sv/atomic_update_hazard_gate.sv]
// A request taken at a clock edge is registered in the input stage (r_in, r_in_vld), then
// its result in the result stage (r_res, o_strobe). Throughput: one request per cycle; the
// in-flight compare against all live FIFO entries and the issue decision sit between them.
// Reset (i_rst_n low, synchronous): clears stall state, held request and FIFO pointers;
// o_busy stays high during reset and until r_live is registered high, then low for good.
// Results cannot be held off by the receiver: each is shown for exactly one cycle.
module atomic_update_hazard_gate
    import aug_pkg::*;
#(
    parameter int unsigned INFLIGHT_DEPTH = 16,
    parameter int unsigned ID_WIDTH       = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_req i_req,
    output logic o_strobe,
    output t_res o_res
);

    localparam int unsigned PTR_W = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(INFLIGHT_DEPTH + 1);

    // Input stage
    logic r_live;
    logic r_in_vld;
    t_req r_in;

    // Scoreboard state
    logic                r_stalled;
    logic [ID_WIDTH-1:0] r_held_vertex;
    logic [ID_WIDTH-1:0] r_held_edge;
    logic [ID_WIDTH-1:0] r_edges [INFLIGHT_DEPTH];
    logic [CNT_W-1:0]    r_count;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;

    // Result stage
    logic r_strobe;
    t_res r_res;

    // Decode-stage signals
    logic                   w_retire;
    logic [PTR_W-1:0]       n_head;
    logic [CNT_W-1:0]       w_cnt_ret;
    logic [CNT_W-1:0]       n_count;
    logic [PTR_W-1:0]       n_tail;
    logic [ID_WIDTH-1:0]    w_cand_vertex;
    logic [ID_WIDTH-1:0]    w_cand_edge;
    logic [CNT_W-1:0]       w_off [INFLIGHT_DEPTH];
    logic [INFLIGHT_DEPTH-1:0] w_hit;
    logic                   w_full;
    logic                   w_go;
    logic                   w_issue;
    logic                   n_stalled;
    logic                   w_take_new;
    logic [1:0]             w_status;
    t_res                   n_res;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(INFLIGHT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_busy   = ~r_live;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // Retire the oldest entry first so a same-tick request sees the freed slot.
    assign w_retire  = r_in_vld && r_in.op_complete && (r_count != '0);
    assign n_head    = w_retire ? next_slot(r_head) : r_head;
    assign w_cnt_ret = r_count - CNT_W'(w_retire);

    // A held request wins; new requests arriving while stalled are dropped.
    assign w_cand_vertex = r_stalled ? r_held_vertex : ID_WIDTH'(r_in.request_vertex);
    assign w_cand_edge   = r_stalled ? r_held_edge   : ID_WIDTH'(r_in.request_edge);

    // Parallel hazard compare; only entries between head and head+count are live.
    always_comb begin
        for (int i = 0; i < INFLIGHT_DEPTH; i++) begin
            if (PTR_W'(i) >= n_head) begin
                w_off[i] = CNT_W'(i) - CNT_W'(n_head);
            end else begin
                w_off[i] = CNT_W'(i + INFLIGHT_DEPTH) - CNT_W'(n_head);
            end
            w_hit[i] = (w_off[i] < w_cnt_ret) && (r_edges[i] == w_cand_edge);
        end
    end

    // A full FIFO blocks just like a matching edge.
    assign w_full = (w_cnt_ret == CNT_W'(INFLIGHT_DEPTH));
    assign w_go   = ~(|w_hit) && ~w_full && r_in.downstream_can_accept;

    always_comb begin
        w_issue    = 1'b0;
        n_stalled  = r_stalled;
        w_take_new = 1'b0;
        w_status   = ST_ACCEPT;
        if (r_in_vld) begin
            if (!r_stalled) begin
                if (r_in.request_valid) begin
                    w_take_new = 1'b1;
                    if (w_go) begin
                        w_issue = 1'b1;
                    end else begin
                        n_stalled = 1'b1;
                        w_status  = ST_STALL_FIRST;
                    end
                end
            end else begin
                if (w_go) begin
                    w_issue   = 1'b1;
                    n_stalled = 1'b0;
                end else begin
                    w_status = ST_STALL_CONT;
                end
            end
        end
    end

    assign n_count = w_cnt_ret + CNT_W'(w_issue);
    assign n_tail  = w_issue ? next_slot(r_tail) : r_tail;

    always_comb begin
        n_res.issue_valid  = w_issue;
        n_res.issue_vertex = w_issue ? IO_ID_W'(w_cand_vertex) : '0;
        n_res.issue_edge   = w_issue ? IO_ID_W'(w_cand_edge) : '0;
        n_res.stall_status = w_status;
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= 1'b0;
            r_in_vld      <= 1'b0;
            r_stalled     <= 1'b0;
            r_held_vertex <= '0;
            r_held_edge   <= '0;
            r_count       <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_strobe      <= 1'b0;
        end else begin
            r_live   <= 1'b1;
            r_in_vld <= i_start && r_live;
            r_strobe <= r_in_vld;
            if (r_in_vld) begin
                r_stalled <= n_stalled;
                r_count   <= n_count;
                r_head    <= n_head;
                r_tail    <= n_tail;
            end
            if (w_take_new) begin
                r_held_vertex <= w_cand_vertex;
                r_held_edge   <= w_cand_edge;
            end
        end
    end

    // Payload registers: request capture, FIFO storage, result.
    always_ff @(posedge i_clk) begin
        if (i_start && r_live) begin
            r_in <= i_req;
        end
        if (w_issue) begin
            r_edges[r_tail] <= w_cand_edge;
        end
        r_res <= n_res;
    end

endmodule

[sv/aug_checker.sv]
// Port-level checker for the atomic update hazard gate, bound into every gate instance.
// Depends on aug_pkg for payload types and stall status codes.
module aug_checker
    import aug_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input t_req i_req,
    input logic o_strobe,
    input t_res o_res
);

    // Every accepted request yields a result via r_in_vld then r_strobe, and no result comes without one.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> ##1 o_strobe)
        else $error("accepted request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy, 2))
        else $error("result without a matching request");

    // An issued request reports accepting; a silent result carries zero ids.
    a_issue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.issue_valid) |-> (o_res.stall_status == ST_ACCEPT))
        else $error("issue with stall status");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.issue_valid) |->
            (o_res.issue_vertex == '0 && o_res.issue_edge == '0))
        else $error("nonzero ids without issue");

    // On consecutive results, an accept status is never followed directly by a continuing stall.
    a_status_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && $past(o_res.stall_status) == ST_ACCEPT)
            |-> (o_res.stall_status != ST_STALL_CONT))
        else $error("continuing stall without first stall");

endmodule

bind atomic_update_hazard_gate aug_checker u_aug_checker (.*);

[dv/tb_atomic_update_hazard_gate.sv]
// Testbench for atomic_update_hazard_gate: directed hazard, full-FIFO, random traffic and
// back-to-back tests, each result checked against an in-bench scoreboard of in-flight edge ids.
// Depends on aug_pkg (payload structs, stall status codes) and the gate RTL.
module tb_atomic_update_hazard_gate;
    timeunit 1ns;
    timeprecision 1ps;

    import aug_pkg::*;

    localparam int unsigned DEPTH = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_req i_req   = '0;
    logic o_busy;
    logic o_strobe;
    t_res o_res;

    atomic_update_hazard_gate dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scoreboard of the gate: held request, stall flag and a ring of
    // in-flight edge ids, stepped once per accepted request.
    // ------------------------------------------------------------------
    logic               gate_stalled = 1'b0;
    logic [IO_ID_W-1:0] held_vtx     = '0;
    logic [IO_ID_W-1:0] held_edge    = '0;
    logic [IO_ID_W-1:0] inflight_ids [DEPTH];
    int unsigned        inflight_cnt = 0;
    int unsigned        rd_ptr       = 0;
    int unsigned        wr_ptr       = 0;

    t_res pending_issues [$];   // expected results, oldest first

    int unsigned n_fail    = 0;
    int unsigned n_items   = 0;
    int unsigned n_issued  = 0;
    int unsigned n_stalls  = 0;
    int unsigned n_full    = 0;
    bit          gaps_on   = 1'b1;

    // A full ring counts as a hazard; otherwise scan only the live entries.
    function automatic bit edge_blocked(input logic [IO_ID_W-1:0] e);
        int unsigned pos;
        if (inflight_cnt >= DEPTH) begin
            n_full++;
            return 1'b1;
        end
        pos = rd_ptr;
        for (int unsigned i = 0; i < inflight_cnt; i++) begin
            if (inflight_ids[pos] == e)
                return 1'b1;
            pos = (pos + 1) % DEPTH;
        end
        return 1'b0;
    endfunction

    function automatic t_res hazard_gate_tick(input t_req r);
        t_res res;
        logic go;
        res = '0;
        go  = 1'b0;
        res.stall_status = ST_ACCEPT;
        // Retire first, so a same-tick completion can clear the hazard.
        if (r.op_complete && inflight_cnt > 0) begin
            rd_ptr = (rd_ptr + 1) % DEPTH;
            inflight_cnt--;
        end
        if (!gate_stalled) begin
            if (r.request_valid) begin
                held_vtx  = r.request_vertex;
                held_edge = r.request_edge;
                if (!edge_blocked(held_edge) && r.downstream_can_accept) begin
                    go = 1'b1;
                end else begin
                    gate_stalled     = 1'b1;
                    res.stall_status = ST_STALL_FIRST;
                    n_stalls++;
                end
            end
        end else if (!edge_blocked(held_edge) && r.downstream_can_accept) begin
            // Retry of the held request succeeds; any new request is dropped.
            go           = 1'b1;
            gate_stalled = 1'b0;
        end else begin
            res.stall_status = ST_STALL_CONT;
        end
        if (go) begin
            inflight_ids[wr_ptr] = held_edge;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            inflight_cnt++;
            n_issued++;
            res.issue_vertex = held_vtx;
            res.issue_edge   = held_edge;
        end
        res.issue_valid = go;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [IO_ID_W-1:0] want,
                                        input logic [IO_ID_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker and request monitor. Both sample pre-edge values, so
    // ordering against the DUT's own updates at the same edge is moot.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_issues.size() == 0) begin
                $error("result strobed with no request waiting");
                n_fail++;
            end else begin
                want = pending_issues.pop_front();
                check_field("issue_valid",  IO_ID_W'(want.issue_valid),
                            IO_ID_W'(o_res.issue_valid));
                check_field("issue_vertex", want.issue_vertex, o_res.issue_vertex);
                check_field("issue_edge",   want.issue_edge,   o_res.issue_edge);
                check_field("stall_status", IO_ID_W'(want.stall_status),
                            IO_ID_W'(o_res.stall_status));
            end
        end
        // Advance the scoreboard on every accepted request.
        if (i_rst_n && i_start && o_busy === 1'b0) begin
            pending_issues.push_back(hazard_gate_tick(i_req));
            n_items++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int unsigned roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold start high until the gate takes the request, then idle for a gap.
    task automatic send_req(input t_req r);
        int gap;
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_req mk_req(input logic rv, input logic [IO_ID_W-1:0] vtx,
                                    input logic [IO_ID_W-1:0] e, input logic acc,
                                    input logic cmp);
        t_req r;
        r.request_valid         = rv;
        r.request_vertex        = vtx;
        r.request_edge          = e;
        r.downstream_can_accept = acc;
        r.op_complete           = cmp;
        return r;
    endfunction

    // Draw edges mostly from a small pool (low ids or their complements) so that
    // hazards are common; a quarter are fully random.
    function automatic t_req rand_req(input int p_req, input int p_acc, input int p_cmp,
                                      input int unsigned pool);
        logic [IO_ID_W-1:0] e;
        if ($urandom_range(0, 3) == 0)
            e = $urandom;
        else begin
            e = $urandom_range(0, pool - 1);
            if ($urandom_range(0, 1))
                e = ~e;
        end
        return mk_req($urandom_range(0, 99) < p_req, $urandom, e,
                      $urandom_range(0, 99) < p_acc, $urandom_range(0, 99) < p_cmp);
    endfunction

    task automatic run_phase(input int n, input int p_req, input int p_acc, input int p_cmp,
                             input int unsigned pool);
        for (int i = 0; i < n; i++)
            send_req(rand_req(p_req, p_acc, p_cmp, pool));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Extreme ids, conflict stall, request dropped while stalled, same-tick
    // completion release, downstream back-pressure, completion on empty FIFO.
    task automatic test_basic_hazards();
        send_req(mk_req(1'b0, '0, '0, 1'b0, 1'b1));              // completion on empty FIFO
        send_req(mk_req(1'b1, '0, '0, 1'b1, 1'b0));              // issue, zero ids
        send_req(mk_req(1'b1, '1, '1, 1'b1, 1'b0));              // issue, all-ones ids
        send_req(mk_req(1'b1, 32'd5, '0, 1'b1, 1'b0));           // conflict on edge 0
        send_req(mk_req(1'b1, 32'd6, 32'd9, 1'b1, 1'b0));        // dropped, stall goes on
        send_req(mk_req(1'b0, '0, '0, 1'b1, 1'b1));              // retire edge 0, issue held
        send_req(mk_req(1'b1, 32'd7, 32'd7, 1'b0, 1'b0));        // downstream busy
        send_req(mk_req(1'b0, '0, '0, 1'b0, 1'b0));              // still busy
        send_req(mk_req(1'b0, '0, '0, 1'b1, 1'b0));              // downstream frees, issue
        repeat (3) send_req(mk_req(1'b0, '0, '0, 1'b0, 1'b1));   // drain to empty
    endtask

    // Fill all in-flight slots with distinct edges, then hit the full stall.
    task automatic test_fifo_full();
        for (int i = 0; i < DEPTH; i++)
            send_req(mk_req(1'b1, $urandom, 32'd100 + i, 1'b1, 1'b0));
        send_req(mk_req(1'b1, 32'hA5A5_5A5A, 32'd500, 1'b1, 1'b0));  // full, first stall
        send_req(mk_req(1'b0, '0, '0, 1'b1, 1'b0));                  // full, continuing
        send_req(mk_req(1'b0, '0, '0, 1'b1, 1'b1));                  // slot frees, issue
    endtask

    task automatic test_random_traffic();
        run_phase(250, 70, 80, 40, 8);     // steady mix, frequent hazards
        run_phase(200, 80, 90, 15, 32);    // few completions: FIFO runs full
        run_phase(200, 60, 50, 70, 4);     // tiny pool, heavy back-pressure, drains
        run_phase(120, 50, 70, 50, 1000);  // wide ids, few conflicts
    endtask

    // No idle cycles at all: one request on every edge.
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_phase(150, 90, 95, 45, 6);
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_hazards();
        test_fifo_full();
        test_random_traffic();
        test_back_to_back();

        i_start <= 1'b0;
        // Wait for every expected result, then let the pipeline settle.
        while (pending_issues.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("Run covered %0d requests: %0d issued, %0d stalls, %0d full-FIFO hazard checks.",
                 n_items, n_issued, n_stalls, n_full);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("timeout: %0d results still expected", pending_issues.size());
        $display("FAILURE");
        $finish;
    end

endmodule
